// ===== hw/rtl/perwb_pkg.sv =====
package perwb_pkg;

  // Field and register widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned LIN_W      = 64;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned LOAD_W     = 8;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DEST_W     = 12;

  // Datapath widths: coefficient times coordinate, sum of three terms, magnitude
  localparam int unsigned PROD_W = 45;
  localparam int unsigned SUM_W  = 46;
  localparam int unsigned MAG_W  = 46;

  // Quotient: 8 integer bits and 8 fraction bits, one bit per divider stage
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned DIV_STEPS = 16;

  // Defaults for the source geometry and the fixed destination limit
  localparam int unsigned SRC_WIDTH_MAX_DEF  = 256;
  localparam int unsigned SRC_HEIGHT_MAX_DEF = 256;
  localparam int unsigned DEST_COORD_MAX     = 4096;

  // Bit positions in warp_mode
  localparam int unsigned MODE_NEAREST = 0;
  localparam int unsigned MODE_BLEND   = 1;

  // Register reset values
  localparam logic [LIN_W-1:0]  RST_NUM_X_LIN = 64'h0000_0000_0010_0000;
  localparam logic [COEF_W-1:0] RST_NUM_X_OFF = 32'h0000_0000;
  localparam logic [LIN_W-1:0]  RST_NUM_Y_LIN = 64'h0010_0000_0000_0000;
  localparam logic [COEF_W-1:0] RST_NUM_Y_OFF = 32'h0000_0000;
  localparam logic [LIN_W-1:0]  RST_DEN_LIN   = 64'h0000_0000_0000_0000;
  localparam logic [COEF_W-1:0] RST_DEN_OFF   = 32'h4000_0000;
  localparam logic [SIZE_W-1:0] RST_SRC_SIZE  = 16'hFFFF;
  localparam logic [MODE_W-1:0] RST_WARP_MODE = 2'b00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_X_LIN = 3'd0,
    CFG_NUM_X_OFF = 3'd1,
    CFG_NUM_Y_LIN = 3'd2,
    CFG_NUM_Y_OFF = 3'd3,
    CFG_DEN_LIN   = 3'd4,
    CFG_DEN_OFF   = 3'd5,
    CFG_SRC_SIZE  = 3'd6,
    CFG_WARP_MODE = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_WARP = 1'b1
  } req_type_e;

  // Request contents carried down the front of the pipeline
  typedef struct packed {
    logic              warp;
    logic [DEST_W-1:0] dx;
    logic [DEST_W-1:0] dy;
    logic [PIX_W-1:0]  bg;
    logic [LOAD_W-1:0] lx;
    logic [LOAD_W-1:0] ly;
    logic [PIX_W-1:0]  lval;
    logic [PIX_W-1:0]  lalpha;
    logic              ok;
  } side_t;

  // Per-pixel tag carried down the sampling stages
  typedef struct packed {
    logic              warp;
    logic [DEST_W-1:0] dx;
    logic [DEST_W-1:0] dy;
    logic [PIX_W-1:0]  bg;
    logic              ok;
  } tag_t;

endpackage

// ===== hw/rtl/perwb_req_if.sv =====
interface perwb_req_if import perwb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [LOAD_W-1:0] load_x;
  logic [LOAD_W-1:0] load_y;
  logic [PIX_W-1:0]  load_value;
  logic [PIX_W-1:0]  load_alpha;
  logic [DEST_W-1:0] dest_x;
  logic [DEST_W-1:0] dest_y;
  logic [PIX_W-1:0]  dest_background;

  modport source (
    output valid, req_type, load_x, load_y, load_value, load_alpha,
           dest_x, dest_y, dest_background,
    input  ready
  );

  modport sink (
    input  valid, req_type, load_x, load_y, load_value, load_alpha,
           dest_x, dest_y, dest_background,
    output ready
  );
endinterface

// ===== hw/rtl/perwb_res_if.sv =====
interface perwb_res_if import perwb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] out_x;
  logic [DEST_W-1:0] out_y;
  logic [PIX_W-1:0]  out_pixel;
  logic              out_written;

  modport source (
    output valid, out_x, out_y, out_pixel, out_written,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_pixel, out_written,
    output ready
  );
endinterface

// ===== hw/rtl/perwb_ram.sv =====
module perwb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/perwb_div.sv =====
module perwb_div import perwb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [MAG_W-1:0]     rem_i,
  input  logic [MAG_W-1:0]     den_i,
  output logic [DIV_STEPS-1:0] quo_o
);

  // One restoring step per stage, quotient built MSB first
  logic [MAG_W-1:0]     rem_q [DIV_STEPS];
  logic [MAG_W-1:0]     den_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [MAG_W-1:0]     rem_in;
    logic [MAG_W-1:0]     den_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [MAG_W:0]       rem_sh;
    logic [MAG_W:0]       rem_sub;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem_sh  = {rem_in, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_in};
    assign take    = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[DIV_STEPS-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

// ===== hw/rtl/perspective_warp_bilinear.sv =====
// Perspective warp with bilinear or nearest sampling. Load transactions write
// one texel and its alpha into the source memories; warp transactions map a
// destination pixel through the homography and return one result each, loads
// return none. One transaction is accepted per clock as long as results are
// taken. A warp passes the capture, affine multiply, sum and sign stages,
// then the two 16-stage restoring dividers (one quotient bit per stage), the
// memory read, blend and alpha mix stages and the output register. The source
// texels sit in four parity banks so the whole 2x2 neighbourhood is read at
// once; loads write at the same stage where warps read, so a warp always sees
// every earlier load. Source memories have no reset: a texel that was never
// loaded reads as an unknown value.
module perspective_warp_bilinear import perwb_pkg::*; #(
  parameter int unsigned SRC_WIDTH_MAX  = SRC_WIDTH_MAX_DEF,
  parameter int unsigned SRC_HEIGHT_MAX = SRC_HEIGHT_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  perwb_req_if.sink             req_i,
  perwb_res_if.source           res_o
);

  // Source geometry
  localparam int unsigned XW   = (SRC_WIDTH_MAX > 1) ? $clog2(SRC_WIDTH_MAX) : 1;
  localparam int unsigned YW   = (SRC_HEIGHT_MAX > 1) ? $clog2(SRC_HEIGHT_MAX) : 1;
  localparam int unsigned XHW  = (XW > 1) ? XW - 1 : 1;
  localparam int unsigned YHW  = (YW > 1) ? YW - 1 : 1;
  localparam int unsigned BANK_DEPTH  = 2 ** (XHW + YHW);
  localparam int unsigned ALPHA_DEPTH = 2 ** (XW + YW);
  localparam int unsigned XMAX = (SRC_WIDTH_MAX - 1 > 255) ? 255 : SRC_WIDTH_MAX - 1;
  localparam int unsigned YMAX = (SRC_HEIGHT_MAX - 1 > 255) ? 255 : SRC_HEIGHT_MAX - 1;

  // Configuration registers
  logic [LIN_W-1:0]  nxl_q, nyl_q, dnl_q;
  logic [COEF_W-1:0] nxo_q, nyo_q, dno_q;
  logic [SIZE_W-1:0] size_q;
  logic [MODE_W-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxl_q  <= RST_NUM_X_LIN;
      nxo_q  <= RST_NUM_X_OFF;
      nyl_q  <= RST_NUM_Y_LIN;
      nyo_q  <= RST_NUM_Y_OFF;
      dnl_q  <= RST_DEN_LIN;
      dno_q  <= RST_DEN_OFF;
      size_q <= RST_SRC_SIZE;
      mode_q <= RST_WARP_MODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_X_LIN: nxl_q  <= cfg_wdata_i;
        CFG_NUM_X_OFF: nxo_q  <= cfg_wdata_i[COEF_W-1:0];
        CFG_NUM_Y_LIN: nyl_q  <= cfg_wdata_i;
        CFG_NUM_Y_OFF: nyo_q  <= cfg_wdata_i[COEF_W-1:0];
        CFG_DEN_LIN:   dnl_q  <= cfg_wdata_i;
        CFG_DEN_OFF:   dno_q  <= cfg_wdata_i[COEF_W-1:0];
        CFG_SRC_SIZE:  size_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_WARP_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic nearest, blend;
  assign nearest = mode_q[MODE_NEAREST];
  assign blend   = mode_q[MODE_BLEND];

  // Last column and row, capped to the memory size
  logic [7:0] maxx, maxy;
  assign maxx = (size_q[7:0] > 8'(XMAX)) ? 8'(XMAX) : size_q[7:0];
  assign maxy = (size_q[15:8] > 8'(YMAX)) ? 8'(YMAX) : size_q[15:8];

  // Whole pipeline moves when the output register is free or being drained
  logic res_vld_q;
  logic adv;
  assign adv         = !res_vld_q || res_o.ready;
  assign req_i.ready = adv;

  // ---------------------------------------------------------------- S0: capture
  logic  s0_vld_q;
  side_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.warp   <= (req_type_e'(req_i.req_type) == REQ_WARP);
      s0_q.dx     <= req_i.dest_x;
      s0_q.dy     <= req_i.dest_y;
      s0_q.bg     <= req_i.dest_background;
      s0_q.lx     <= req_i.load_x;
      s0_q.ly     <= req_i.load_y;
      s0_q.lval   <= req_i.load_value;
      s0_q.lalpha <= req_i.load_alpha;
      s0_q.ok     <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- S1: products
  logic signed [DEST_W:0] xs, ys;
  assign xs = $signed({1'b0, s0_q.dx});
  assign ys = $signed({1'b0, s0_q.dy});

  logic signed [PROD_W-1:0] pnxx_d, pnxy_d, pnyx_d, pnyy_d, pdnx_d, pdny_d;
  assign pnxx_d = $signed(nxl_q[COEF_W-1:0]) * xs;
  assign pnxy_d = $signed(nxl_q[LIN_W-1:COEF_W]) * ys;
  assign pnyx_d = $signed(nyl_q[COEF_W-1:0]) * xs;
  assign pnyy_d = $signed(nyl_q[LIN_W-1:COEF_W]) * ys;
  assign pdnx_d = $signed(dnl_q[COEF_W-1:0]) * xs;
  assign pdny_d = $signed(dnl_q[LIN_W-1:COEF_W]) * ys;

  logic                     s1_vld_q;
  side_t                    s1_q;
  logic signed [PROD_W-1:0] pnxx_q, pnxy_q, pnyx_q, pnyy_q, pdnx_q, pdny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q   <= s0_q;
      pnxx_q <= pnxx_d;
      pnxy_q <= pnxy_d;
      pnyx_q <= pnyx_d;
      pnyy_q <= pnyy_d;
      pdnx_q <= pdnx_d;
      pdny_q <= pdny_d;
    end
  end

  // ---------------------------------------------------------------- S2: sums
  logic signed [SUM_W-1:0] nx_d, ny_d, dn_d;
  assign nx_d = SUM_W'(pnxx_q) + SUM_W'(pnxy_q) + SUM_W'($signed(nxo_q));
  assign ny_d = SUM_W'(pnyx_q) + SUM_W'(pnyy_q) + SUM_W'($signed(nyo_q));
  assign dn_d = SUM_W'(pdnx_q) + SUM_W'(pdny_q) + SUM_W'($signed(dno_q));

  logic                    s2_vld_q;
  side_t                   s2_q;
  logic signed [SUM_W-1:0] nx_q, ny_q, dn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= s1_q;
      nx_q <= nx_d;
      ny_q <= ny_d;
      dn_q <= dn_d;
    end
  end

  // ---------------------------------------------------------------- S3: sign, magnitude
  logic [MAG_W-1:0] mnx, mny, mdn;
  assign mnx = nx_q[SUM_W-1] ? MAG_W'(-nx_q) : MAG_W'(nx_q);
  assign mny = ny_q[SUM_W-1] ? MAG_W'(-ny_q) : MAG_W'(ny_q);
  assign mdn = dn_q[SUM_W-1] ? MAG_W'(-dn_q) : MAG_W'(dn_q);

  // Quotient fits 16 bits only when 4*|n| < |d|
  logic ovx, ovy, negx, negy, okx, oky, dest_ok, ok_d;
  assign ovx  = ({mnx, 2'b00} >= {2'b00, mdn});
  assign ovy  = ({mny, 2'b00} >= {2'b00, mdn});
  assign negx = nx_q[SUM_W-1] ^ dn_q[SUM_W-1];
  assign negy = ny_q[SUM_W-1] ^ dn_q[SUM_W-1];
  // A negative quotient is only acceptable when the numerator is zero
  assign okx  = !ovx && !(negx && (mnx != '0));
  assign oky  = !ovy && !(negy && (mny != '0));
  assign dest_ok = ({20'd0, s2_q.dx} < 32'(DEST_COORD_MAX))
                && ({20'd0, s2_q.dy} < 32'(DEST_COORD_MAX));
  assign ok_d = okx && oky && dest_ok && (dn_q != '0);

  logic             s3_vld_q;
  side_t            s3_q;
  logic [MAG_W-1:0] remx_q, remy_q, md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q    <= s2_q;
      s3_q.ok <= ok_d;
      remx_q  <= {mnx[MAG_W-3:0], 2'b00};
      remy_q  <= {mny[MAG_W-3:0], 2'b00};
      md_q    <= mdn;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [DIV_STEPS-1:0] qx, qy;

  perwb_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (remx_q),
    .den_i (md_q),
    .quo_o (qx)
  );

  perwb_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .rem_i (remy_q),
    .den_i (md_q),
    .quo_o (qy)
  );

  // Side line matching the divider depth
  logic  ln_vld_q [DIV_STEPS];
  side_t ln_q     [DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        ln_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      ln_vld_q[0] <= s3_vld_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        ln_vld_q[k] <= ln_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ln_q[0] <= s3_q;
      for (int k = 1; k < DIV_STEPS; k++) begin
        ln_q[k] <= ln_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- E: bounds, memory access
  side_t      tail;
  logic       tail_vld;
  logic [7:0] ix, iy;
  logic       e_ok_d;
  assign tail     = ln_q[DIV_STEPS-1];
  assign tail_vld = ln_vld_q[DIV_STEPS-1];
  assign ix       = qx[DIV_STEPS-1:FRAC_W];
  assign iy       = qy[DIV_STEPS-1:FRAC_W];
  assign e_ok_d   = tail.ok
                 && (nearest ? (ix <= maxx) : (ix < maxx))
                 && (nearest ? (iy <= maxy) : (iy < maxy));

  // Load address and bank select
  logic                 ld_in;
  logic [XHW+YHW-1:0]   ld_wa;
  logic [XW+YW-1:0]     ld_awa;
  logic                 ld_we;
  assign ld_in  = ({24'd0, tail.lx} < 32'(SRC_WIDTH_MAX))
               && ({24'd0, tail.ly} < 32'(SRC_HEIGHT_MAX));
  assign ld_we  = adv && tail_vld && !tail.warp && ld_in;
  assign ld_wa  = {YHW'(YW'(tail.ly) >> 1), XHW'(XW'(tail.lx) >> 1)};
  assign ld_awa = {YW'(tail.ly), XW'(tail.lx)};

  // Read addresses: bank b holds texels with x parity b[0] and y parity b[1]
  logic [7:0]         bk_xc [4];
  logic [7:0]         bk_yc [4];
  logic [XHW+YHW-1:0] bk_ra [4];
  logic               bk_we [4];
  logic [PIX_W-1:0]   bk_rd [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bk_xc[b] = (ix[0] == b[0]) ? ix : ix + 8'd1;
      bk_yc[b] = (iy[0] == b[1]) ? iy : iy + 8'd1;
      bk_ra[b] = {YHW'(YW'(bk_yc[b]) >> 1), XHW'(XW'(bk_xc[b]) >> 1)};
      bk_we[b] = ld_we && ({tail.ly[0], tail.lx[0]} == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    perwb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_pix_ram (
      .clk_i   (clk_i),
      .we_i    (bk_we[b]),
      .waddr_i (ld_wa),
      .wdata_i (tail.lval),
      .re_i    (adv),
      .raddr_i (bk_ra[b]),
      .rdata_o (bk_rd[b])
    );
  end

  logic [PIX_W-1:0] alpha_rd;

  perwb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (ALPHA_DEPTH)
  ) u_alpha_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_awa),
    .wdata_i (tail.lalpha),
    .re_i    (adv),
    .raddr_i ({YW'(iy), XW'(ix)}),
    .rdata_o (alpha_rd)
  );

  logic              e_vld_q;
  tag_t              e_tag_q;
  logic [FRAC_W-1:0] e_wx_q, e_wy_q;
  logic              e_x0_q, e_y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= tail_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_tag_q.warp <= tail.warp;
      e_tag_q.dx   <= tail.dx;
      e_tag_q.dy   <= tail.dy;
      e_tag_q.bg   <= tail.bg;
      e_tag_q.ok   <= e_ok_d;
      e_wx_q       <= qx[FRAC_W-1:0];
      e_wy_q       <= qy[FRAC_W-1:0];
      e_x0_q       <= ix[0];
      e_y0_q       <= iy[0];
    end
  end

  // ---------------------------------------------------------------- F: horizontal blend
  logic [PIX_W-1:0] p00, p01, p10, p11;
  assign p00 = bk_rd[{e_y0_q, e_x0_q}];
  assign p01 = bk_rd[{e_y0_q, ~e_x0_q}];
  assign p10 = bk_rd[{~e_y0_q, e_x0_q}];
  assign p11 = bk_rd[{~e_y0_q, ~e_x0_q}];

  logic [15:0] top_d, bot_d;
  assign top_d = 16'(p00) * (16'd256 - 16'(e_wx_q)) + 16'(p01) * 16'(e_wx_q);
  assign bot_d = 16'(p10) * (16'd256 - 16'(e_wx_q)) + 16'(p11) * 16'(e_wx_q);

  logic              f_vld_q;
  tag_t              f_tag_q;
  logic [15:0]       f_top_q, f_bot_q;
  logic [PIX_W-1:0]  f_p00_q, f_alpha_q;
  logic [FRAC_W-1:0] f_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_tag_q   <= e_tag_q;
      f_top_q   <= top_d;
      f_bot_q   <= bot_d;
      f_p00_q   <= p00;
      f_alpha_q <= alpha_rd;
      f_wy_q    <= e_wy_q;
    end
  end

  // ---------------------------------------------------------------- G: vertical blend
  logic [23:0]      bil_d;
  logic [PIX_W-1:0] smp_d;
  assign bil_d = 24'(f_top_q) * (24'd256 - 24'(f_wy_q)) + 24'(f_bot_q) * 24'(f_wy_q);
  assign smp_d = nearest ? f_p00_q : bil_d[23:16];

  logic             g_vld_q;
  tag_t             g_tag_q;
  logic [PIX_W-1:0] g_smp_q, g_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (adv) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_tag_q   <= f_tag_q;
      g_smp_q   <= smp_d;
      g_alpha_q <= f_alpha_q;
    end
  end

  // ---------------------------------------------------------------- H: alpha mix
  logic [15:0] mix_d;
  assign mix_d = 16'(g_smp_q) * 16'(g_alpha_q)
               + 16'(g_tag_q.bg) * (16'd255 - 16'(g_alpha_q));

  logic        h_vld_q;
  tag_t        h_tag_q;
  logic [15:0] h_mix_q;
  logic [PIX_W-1:0] h_smp_q;
  logic        h_blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (adv) begin
      h_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_tag_q   <= g_tag_q;
      h_mix_q   <= mix_d;
      h_smp_q   <= g_smp_q;
      h_blend_q <= blend;
    end
  end

  // ---------------------------------------------------------------- output register
  // x/255 for x up to 255*255: (x + (x >> 8) + 1) >> 8
  logic [15:0]      div_t;
  logic [PIX_W-1:0] pix_d;
  assign div_t = h_mix_q + (h_mix_q >> 8) + 16'd1;
  assign pix_d = !h_tag_q.ok ? h_tag_q.bg
               : (h_blend_q ? div_t[15:8] : h_smp_q);

  logic [DEST_W-1:0] res_x_q, res_y_q;
  logic [PIX_W-1:0]  res_pix_q;
  logic              res_wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= h_vld_q && h_tag_q.warp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_x_q   <= h_tag_q.dx;
      res_y_q   <= h_tag_q.dy;
      res_pix_q <= pix_d;
      res_wr_q  <= h_tag_q.ok;
    end
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.out_x       = res_x_q;
  assign res_o.out_y       = res_y_q;
  assign res_o.out_pixel   = res_pix_q;
  assign res_o.out_written = res_wr_q;

endmodule

// ===== tb/perwb_tb_pkg.sv =====
`timescale 1ns / 100ps
package perwb_tb_pkg;
  import perwb_pkg::*;

  // One request transaction, with an optional hand-typed expectation
  typedef struct {
    req_type_e         kind;
    logic [LOAD_W-1:0] lx;
    logic [LOAD_W-1:0] ly;
    logic [PIX_W-1:0]  lval;
    logic [PIX_W-1:0]  lalpha;
    logic [DEST_W-1:0] dx;
    logic [DEST_W-1:0] dy;
    logic [PIX_W-1:0]  bg;
    bit                typed;
    logic [PIX_W-1:0]  exp_pix;
    bit                exp_wr;
  } warp_req_t;

  // Result fields as they leave the block
  typedef struct {
    logic [DEST_W-1:0] x;
    logic [DEST_W-1:0] y;
    logic [PIX_W-1:0]  pix;
    logic              wr;
  } warp_res_t;
endpackage

// ===== tb/perwb_tb_ifs.sv =====
`timescale 1ns / 100ps
// Transaction types live in the package; this file only holds the
// configuration interface that the bench drives into the block.
interface perwb_cfg_if import perwb_pkg::*; ();
  logic                  we;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output we, idx, wdata);
  modport sink (input we, idx, wdata);
endinterface

// ===== tb/tb_perspective_warp_bilinear.sv =====
`timescale 1ns / 100ps
module tb_perspective_warp_bilinear;
  import perwb_pkg::*;
  import perwb_tb_pkg::*;

  localparam int  WD_LIMIT  = 3000;
  localparam int  HOLD_LEN  = 400;
  localparam int  RAND_ITEMS = 210;
  localparam longint COORD_SAT = 64'sd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  perwb_req_if req_if ();
  perwb_res_if res_if ();
  perwb_cfg_if cfg_if ();

  perspective_warp_bilinear u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_if.we),
    .cfg_idx_i   (cfg_if.idx),
    .cfg_wdata_i (cfg_if.wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the register file and the source memories
  logic [LIN_W-1:0]  sh_nx_lin, sh_ny_lin, sh_den_lin;
  logic [COEF_W-1:0] sh_nx_off, sh_ny_off, sh_den_off;
  logic [SIZE_W-1:0] sh_size;
  logic [MODE_W-1:0] sh_mode;
  logic [7:0] tex_pix [65536];
  logic [7:0] tex_alpha [65536];
  bit         tex_set [65536];

  warp_res_t pending_px[$];
  int        errors = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint affine(input logic [63:0] lin, input logic [31:0] off,
                                    input longint x, input longint y);
    return longint'(signed'(lin[31:0])) * x + longint'(signed'(lin[63:32])) * y
           + longint'(signed'(off));
  endfunction

  // floor(n * 2^18 / d) with saturated magnitude
  function automatic longint q8_quot(input longint n, input longint d);
    bit neg;
    longint unsigned mn, md, q, r;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? longint'(-n) : n;
    md = (d < 0) ? longint'(-d) : d;
    q = mn / md;
    r = mn % md;
    if (q >= (64'd1 << 22)) return neg ? -COORD_SAT : COORD_SAT;
    for (int i = 0; i < 18; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= md) begin
        r -= md;
        q |= 1;
      end
    end
    if (neg) return -longint'(q + ((r != 0) ? 1 : 0));
    return longint'(q);
  endfunction

  // Expected pixel for one warp; safe drops to 0 if an unloaded texel is read
  function automatic void warp_pixel(input warp_req_t t, output logic [7:0] pix,
                                     output bit wr, output bit safe);
    longint den, u, v, ix, iy, limx, limy;
    longint unsigned a, wx, wy, top, bot, s, al;
    bit nearest;
    pix = t.bg;
    wr = 1'b0;
    safe = 1'b1;
    nearest = sh_mode[MODE_NEAREST];
    den = affine(sh_den_lin, sh_den_off, t.dx, t.dy);
    if (den == 0) return;
    u = q8_quot(affine(sh_nx_lin, sh_nx_off, t.dx, t.dy), den);
    v = q8_quot(affine(sh_ny_lin, sh_ny_off, t.dx, t.dy), den);
    if (u < 0 || v < 0) return;
    limx = nearest ? sh_size[7:0] : longint'(sh_size[7:0]) - 1;
    limy = nearest ? sh_size[15:8] : longint'(sh_size[15:8]) - 1;
    ix = u >>> 8;
    iy = v >>> 8;
    if (ix > limx || iy > limy) return;
    a = iy * 256 + ix;
    al = tex_alpha[a];
    if (nearest) begin
      safe = tex_set[a];
      s = tex_pix[a];
    end else begin
      safe = tex_set[a] && tex_set[a+1] && tex_set[a+256] && tex_set[a+257];
      wx = u & 255;
      wy = v & 255;
      top = tex_pix[a] * (256 - wx) + tex_pix[a+1] * wx;
      bot = tex_pix[a+256] * (256 - wx) + tex_pix[a+257] * wx;
      s = (top * (256 - wy) + bot * wy) >> 16;
    end
    if (sh_mode[MODE_BLEND]) s = (s * al + t.bg * (255 - al)) / 255;
    pix = s[7:0];
    wr = 1'b1;
  endfunction

  // Result side: check against the oldest expectation, stall at random or on hold_req
  always @(posedge clk_i or negedge rst_ni) begin
    warp_res_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_px.size() == 0) begin
          report("unexpected result", res_if.out_x, 0);
        end else begin
          want = pending_px.pop_front();
          if (res_if.out_x !== want.x) report("out_x", res_if.out_x, want.x);
          if (res_if.out_y !== want.y) report("out_y", res_if.out_y, want.y);
          if (res_if.out_pixel !== want.pix) report("out_pixel", res_if.out_pixel, want.pix);
          if (res_if.out_written !== want.wr) report("out_written", res_if.out_written, want.wr);
        end
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req) begin
        res_if.ready <= 1'b0;
        hold_left <= HOLD_LEN;
      end else begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_LIMIT) begin
      $display("tb_perspective_warp_bilinear: errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] data);
    cfg_if.we <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_NUM_X_LIN: sh_nx_lin = data;
      CFG_NUM_X_OFF: sh_nx_off = data[31:0];
      CFG_NUM_Y_LIN: sh_ny_lin = data;
      CFG_NUM_Y_OFF: sh_ny_off = data[31:0];
      CFG_DEN_LIN:   sh_den_lin = data;
      CFG_DEN_OFF:   sh_den_off = data[31:0];
      CFG_SRC_SIZE:  sh_size = data[15:0];
      CFG_WARP_MODE: sh_mode = data[1:0];
      default: ;
    endcase
  endtask

  // Offer one transaction, wait for acceptance, then predict
  task automatic send_req(input warp_req_t t);
    warp_res_t r;
    bit safe;
    int a;
    while (!calm && $urandom_range(0, 99) < 28) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= t.kind;
    req_if.load_x <= t.lx;
    req_if.load_y <= t.ly;
    req_if.load_value <= t.lval;
    req_if.load_alpha <= t.lalpha;
    req_if.dest_x <= t.dx;
    req_if.dest_y <= t.dy;
    req_if.dest_background <= t.bg;
    do @(posedge clk_i); while (!req_if.ready);
    if (t.kind == REQ_LOAD) begin
      a = t.ly * 256 + t.lx;
      tex_pix[a] = t.lval;
      tex_alpha[a] = t.lalpha;
      tex_set[a] = 1'b1;
    end else begin
      r.x = t.dx;
      r.y = t.dy;
      if (t.typed) begin
        r.pix = t.exp_pix;
        r.wr = t.exp_wr;
      end else begin
        warp_pixel(t, r.pix, r.wr, safe);
      end
      pending_px.push_back(r);
    end
  endtask

  function automatic warp_req_t load_req(input int x, input int y);
    warp_req_t t;
    t = '{kind: REQ_LOAD, lx: LOAD_W'(x), ly: LOAD_W'(y), lval: PIX_W'($urandom),
          lalpha: PIX_W'($urandom), dx: DEST_W'($urandom), dy: DEST_W'($urandom),
          bg: PIX_W'($urandom), typed: 0, exp_pix: 0, exp_wr: 0};
    return t;
  endfunction

  function automatic warp_req_t warp_req(input int x, input int y, input int bg);
    warp_req_t t;
    t = '{kind: REQ_WARP, lx: LOAD_W'($urandom), ly: LOAD_W'($urandom),
          lval: PIX_W'($urandom), lalpha: PIX_W'($urandom),
          dx: DEST_W'(x), dy: DEST_W'(y), bg: PIX_W'(bg), typed: 0, exp_pix: 0, exp_wr: 0};
    return t;
  endfunction

  function automatic warp_req_t typed_warp(input int x, input int y, input int bg,
                                           input int pix, input bit wr);
    warp_req_t t;
    t = warp_req(x, y, bg);
    t.typed = 1'b1;
    t.exp_pix = PIX_W'(pix);
    t.exp_wr = wr;
    return t;
  endfunction

  // Random mix: mostly warps whose prediction reads only loaded texels, some loads in the corner or anywhere
  function automatic warp_req_t random_req();
    warp_req_t t;
    logic [7:0] p;
    bit wr, safe;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1)) return load_req($urandom_range(0, 31), $urandom_range(0, 31));
      return load_req($urandom_range(0, 255), $urandom_range(0, 255));
    end
    for (int k = 0; k < 10; k++) begin
      case ($urandom_range(0, 2))
        0: t = warp_req($urandom_range(0, 40), $urandom_range(0, 40), $urandom);
        1: t = warp_req($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
        default: t = warp_req($urandom_range(0, 300), $urandom_range(0, 4095), $urandom);
      endcase
      warp_pixel(t, p, wr, safe);
      if (safe) return t;
    end
    return load_req($urandom_range(0, 31), $urandom_range(0, 31));
  endfunction

  task automatic drain();
    req_if.valid <= 1'b0;
    cfg_if.we <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Register sets for the phases after reset
  logic [63:0] phase_regs [5][8] = '{
    '{64'h00002000_00000000 | 64'h0, 64'h0, 64'h00000000_00002000 << 32, 64'h0,
      64'h0, 64'h40000000, 64'h1F1F, 64'h3},
    '{64'h00000100_00004000, 64'hFFB00000, 64'h00004000_00000100, 64'hFFF00000,
      64'h00000400_00000800, 64'h40000000, 64'hFFFF, 64'h0},
    '{64'hFFFFFFFF_FFFFFFFF, 64'h7FFFFFFF, 64'hFFFFFFFF_FFFFFFFF, 64'h80000000,
      64'h80000000_7FFFFFFF, 64'h80000000, 64'h0000, 64'h2},
    '{64'h00000000_00002000, 64'h0, 64'h00002000_00000000, 64'h0,
      64'h0, 64'h0, 64'h00FF, 64'h1},
    '{64'h00000000_FFFFE000, 64'h0, 64'hFFFFE000_00000000, 64'h0,
      64'h0, 64'hC0000000, 64'h2020, 64'h0}
  };

  warp_req_t directed [$];

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = REQ_LOAD;
    req_if.load_x = '0;
    req_if.load_y = '0;
    req_if.load_value = '0;
    req_if.load_alpha = '0;
    req_if.dest_x = '0;
    req_if.dest_y = '0;
    req_if.dest_background = '0;
    cfg_if.we = 1'b0;
    cfg_if.idx = CFG_NUM_X_LIN;
    cfg_if.wdata = '0;
    sh_nx_lin = RST_NUM_X_LIN;
    sh_nx_off = RST_NUM_X_OFF;
    sh_ny_lin = RST_NUM_Y_LIN;
    sh_ny_off = RST_NUM_Y_OFF;
    sh_den_lin = RST_DEN_LIN;
    sh_den_off = RST_DEN_OFF;
    sh_size = RST_SRC_SIZE;
    sh_mode = RST_WARP_MODE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill a corner of the source so warps have texels to read
    for (int y = 0; y < 24; y++)
      for (int x = 0; x < 24; x++)
        send_req(load_req(x, y));

    // Directed rows under the reset (identity, bilinear) mapping
    directed.push_back('{REQ_LOAD, 0, 0, 10, 255, 0, 0, 0, 0, 0, 0});
    directed.push_back('{REQ_LOAD, 255, 255, 255, 255, 4095, 4095, 255, 0, 0, 0});
    directed.push_back('{REQ_LOAD, 254, 254, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{REQ_LOAD, 255, 254, 128, 1, 0, 0, 0, 0, 0, 0});
    directed.push_back('{REQ_LOAD, 254, 255, 77, 200, 0, 0, 0, 0, 0, 0});
    directed.push_back(typed_warp(0, 0, 8'h55, 10, 1'b1));
    directed.push_back(warp_req(254, 254, 8'hFF));
    directed.push_back(typed_warp(255, 255, 8'hAA, 8'hAA, 1'b0));
    directed.push_back(typed_warp(255, 0, 8'h01, 8'h01, 1'b0));
    directed.push_back(typed_warp(4095, 4095, 8'h00, 8'h00, 1'b0));
    directed.push_back(typed_warp(4095, 0, 8'h12, 8'h12, 1'b0));
    directed.push_back(typed_warp(0, 4095, 8'h34, 8'h34, 1'b0));
    directed.push_back(warp_req(3, 5, 8'h80));
    directed.push_back(warp_req(22, 22, 8'h7F));
    foreach (directed[i]) send_req(directed[i]);
    repeat (RAND_ITEMS) send_req(random_req());

    // Phases: each one drains, reprograms and runs random traffic
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      for (int r = 0; r < 8; r++) write_reg(cfg_idx_e'(r), phase_regs[ph][r]);
      cfg_if.we <= 1'b0;
      calm = (ph == 0);
      if (ph == 1) begin
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      repeat (RAND_ITEMS) send_req(random_req());
      calm = 1'b0;
    end

    drain();
    if (errors == 0)
      $display("tb_perspective_warp_bilinear: clean");
    else
      $display("tb_perspective_warp_bilinear: errors");
    $finish;
  end
endmodule
